>>> src/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int ELEM_W        = 16;  // element port width
    localparam int PROD_W        = 35;  // result port width
    localparam int OUT_IDX_W     = 3;   // row/col port width
    localparam int CFG_W         = 4;   // configuration data width
    localparam int CFG_IDX_W     = 2;   // configuration index width
    localparam int MAX_DIM_DEF   = 8;
    localparam int ELEM_BITS_DEF = 16;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_OF_A  = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_COLS_OF_B  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic div_start;
        logic store;
        logic issue;
    } imm_cmd_t;

    typedef struct packed {
        logic resync;
        logic div_done;
        logic complete;
        logic loading_b;
        logic issue_last;
        logic en;
        logic pipe_empty;
    } imm_status_t;

endpackage

>>> src/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Signed integer matrix product C = A x B with streamed elements and results.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data set rows_of_a (0), inner_size (1)
//   and cols_of_b (2); 0 reads as 1, values above MAX_DIM as MAX_DIM.
//   s_valid/s_ready transfer elements: all of A row-major, then all of B.
//   m_valid/m_ready transfer results row-major with row, column and a last
//   flag on the final one.
// Sequencing:
//   each element is accepted, then written in a store step. The first element
//   after a register write waits while the load position is recovered
//   in a one-bit-per-cycle restoring divider.
//   After the last element of B the MAC pipeline issues one multiply per
//   cycle while not stalled, rows*cols*inner in all; each result passes the
//   operand, product and result registers; the pipe drains before new loads.
// Reset:
//   dimensions return to 8, loading restarts with A; stores are not cleared.
// Stall:
//   a held result stalls the MAC pipeline only when the next result is due;
//   element loading continues while the final result waits.
// ----------------------------------------------------------------------------
module integer_matrix_multiply #(
    parameter int MAX_DIM   = imm_pkg::MAX_DIM_DEF,
    parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [imm_pkg::ELEM_W-1:0]    s_element_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [imm_pkg::PROD_W-1:0]    m_product_value,
    output logic [imm_pkg::OUT_IDX_W-1:0] m_out_row,
    output logic [imm_pkg::OUT_IDX_W-1:0] m_out_col,
    output logic                          m_last_result
);
    import imm_pkg::*;

    imm_cmd_t    cmd;
    imm_status_t status;
    logic        cfg_fire, in_fire;

    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_fire  = s_valid && s_ready;

    imm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .status    (status),
        .cmd       (cmd),
        .s_ready   (s_ready),
        .cfg_ready (cfg_ready)
    );

    imm_datapath #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_fire        (cfg_fire),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_fire         (in_fire),
        .in_elem         (s_element_value),
        .cmd             (cmd),
        .status          (status),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_product_value (m_product_value),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_last_result   (m_last_result)
    );

`ifndef ASSERT_OFF
    // an element transfer always drops ready while the element waits for its store
    a_store_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("element transfer not followed by a busy cycle");

    // no multiply-accumulate is in flight while elements are taken
    a_pipe_empty_when_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> status.pipe_empty)
        else $error("mac pipeline busy while accepting elements");

    // completing B starts the multiply sweep
    a_run_after_b: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.store && status.complete && status.loading_b) |=> cmd.issue)
        else $error("multiply sweep did not start after last element of B");
`endif

endmodule

>>> src/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl
// Controller: sequences element loads, position recovery after a register
// change, and the multiply-accumulate sweep.
// ----------------------------------------------------------------------------
module imm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  imm_pkg::imm_status_t status,
    output imm_pkg::imm_cmd_t    cmd,
    output logic                 s_ready,
    output logic                 cfg_ready
);
    import imm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_DIV,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (status.resync) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.store = 1'b1;
                    if (status.complete && status.loading_b) begin
                        state_next = ST_RUN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (status.en && status.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready   = ready_reg;
    assign cfg_ready = ready_reg;

endmodule

>>> src/imm_datapath.sv
// ----------------------------------------------------------------------------
// imm_datapath
// Datapath: dimension registers, element stores, load position counters,
// restoring divider for position recovery, MAC pipeline and result register.
// ----------------------------------------------------------------------------
module imm_datapath #(
    parameter int MAX_DIM   = imm_pkg::MAX_DIM_DEF,
    parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_fire,
    input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_fire,
    input  logic [imm_pkg::ELEM_W-1:0]    in_elem,
    input  imm_pkg::imm_cmd_t             cmd,
    output imm_pkg::imm_status_t          status,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [imm_pkg::PROD_W-1:0]    m_product_value,
    output logic [imm_pkg::OUT_IDX_W-1:0] m_out_row,
    output logic [imm_pkg::OUT_IDX_W-1:0] m_out_col,
    output logic                          m_last_result
);
    import imm_pkg::*;

    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int LC_W      = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int SIZE_W    = 2 * DIM_W;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int MUL_W     = 2 * ELEM_BITS;
    localparam int EXT_W     = (MUL_W > PROD_W) ? MUL_W : PROD_W;
    localparam int DCNT_W    = $clog2(LC_W + 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    // configuration
    logic [CFG_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0] r_dim, n_dim, c_dim, width;
    logic [SIZE_W-1:0] size;

    // load side
    logic [ELEM_BITS-1:0] elem_reg;
    logic [ELEM_BITS-1:0] store_a [MEM_DEPTH];
    logic [ELEM_BITS-1:0] store_b [MEM_DEPTH];
    logic [LC_W-1:0]      load_count_reg, lc_inc;
    logic                 loading_b_reg;
    logic [IDX_W-1:0]     row_reg, col_reg;
    logic                 in_range, complete, col_wrap;
    logic                 resync_reg;

    // divider
    logic [LC_W-1:0]   dq_reg, dq_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W:0]    trial;
    logic              ge;
    logic [DCNT_W-1:0] dcnt_reg;

    // compute sweep
    logic [IDX_W-1:0] i_reg, j_reg, k_reg;
    logic             i_last, j_last, k_last, issue_fire, en;
    logic             v1_reg, v2_reg;
    logic [IDX_W-1:0] row1_reg, col1_reg, row2_reg, col2_reg;
    logic             first1_reg, last1_reg, fin1_reg;
    logic             first2_reg, last2_reg, fin2_reg;
    logic [ELEM_BITS-1:0]    a_rd_reg, b_rd_reg;
    logic signed [MUL_W-1:0] prod_reg;
    logic signed [EXT_W-1:0] prod_ext;
    logic [PROD_W-1:0]       acc_reg, acc_sum;
    logic                    m_valid_reg;

    assign r_dim = clamp_dim(rows_reg);
    assign n_dim = clamp_dim(inner_reg);
    assign c_dim = clamp_dim(cols_reg);
    assign width = loading_b_reg ? c_dim : n_dim;
    assign size  = loading_b_reg ? SIZE_W'(n_dim) * SIZE_W'(c_dim)
                                 : SIZE_W'(r_dim) * SIZE_W'(n_dim);

    assign lc_inc   = load_count_reg + LC_W'(1);
    assign in_range = SIZE_W'(load_count_reg) < size;
    assign complete = !in_range || (SIZE_W'(lc_inc) == size);
    assign col_wrap = (DIM_W'(col_reg) + DIM_W'(1)) == width;

    assign trial    = {rem_reg, dq_reg[LC_W-1]};
    assign ge       = trial >= {1'b0, width};
    assign rem_next = ge ? DIM_W'(trial - {1'b0, width}) : trial[DIM_W-1:0];
    assign dq_next  = {dq_reg[LC_W-2:0], ge};

    assign i_last     = (DIM_W'(i_reg) + DIM_W'(1)) == r_dim;
    assign j_last     = (DIM_W'(j_reg) + DIM_W'(1)) == c_dim;
    assign k_last     = (DIM_W'(k_reg) + DIM_W'(1)) == n_dim;
    assign en         = !(v2_reg && last2_reg && m_valid_reg && !m_ready);
    assign issue_fire = cmd.issue && en;

    assign prod_ext = EXT_W'(prod_reg);
    assign acc_sum  = (first2_reg ? '0 : acc_reg) + prod_ext[PROD_W-1:0];

    // configuration and load/compute control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg       <= CFG_DIM_RESET;
            inner_reg      <= CFG_DIM_RESET;
            cols_reg       <= CFG_DIM_RESET;
            load_count_reg <= '0;
            loading_b_reg  <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            resync_reg     <= 1'b0;
            dcnt_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
        end else begin
            if (cfg_fire) begin
                resync_reg <= 1'b1;
                if (cfg_index == CFG_ROWS_OF_A) begin
                    rows_reg <= cfg_data;
                end
                if (cfg_index == CFG_INNER_SIZE) begin
                    inner_reg <= cfg_data;
                end
                if (cfg_index == CFG_COLS_OF_B) begin
                    cols_reg <= cfg_data;
                end
            end
            if (cmd.div_start) begin
                dcnt_reg <= DCNT_W'(LC_W);
            end else if (dcnt_reg != '0) begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1)) begin
                    row_reg    <= dq_next[IDX_W-1:0];
                    col_reg    <= rem_next[IDX_W-1:0];
                    resync_reg <= 1'b0;
                end
            end
            if (cmd.store) begin
                if (complete) begin
                    load_count_reg <= '0;
                    row_reg        <= '0;
                    col_reg        <= '0;
                    loading_b_reg  <= !loading_b_reg;
                end else begin
                    load_count_reg <= lc_inc;
                    if (col_wrap) begin
                        col_reg <= '0;
                        row_reg <= row_reg + IDX_W'(1);
                    end else begin
                        col_reg <= col_reg + IDX_W'(1);
                    end
                end
            end
            if (issue_fire) begin
                if (k_last) begin
                    k_reg <= '0;
                    if (j_last) begin
                        j_reg <= '0;
                        i_reg <= i_last ? '0 : i_reg + IDX_W'(1);
                    end else begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end else begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
        end
    end

    // element latch, divider shift registers, stores
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            elem_reg <= ELEM_BITS'($unsigned(in_elem));
        end
        if (cmd.div_start) begin
            dq_reg  <= load_count_reg;
            rem_reg <= '0;
        end else if (dcnt_reg != '0) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
        if (cmd.store && in_range && !loading_b_reg) begin
            store_a[{row_reg, col_reg}] <= elem_reg;
        end
        if (cmd.store && in_range && loading_b_reg) begin
            store_b[{row_reg, col_reg}] <= elem_reg;
        end
        if (issue_fire) begin
            a_rd_reg <= store_a[{i_reg, k_reg}];
            b_rd_reg <= store_b[{k_reg, j_reg}];
        end
    end

    // mac pipeline valids and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                v1_reg <= issue_fire;
                v2_reg <= v1_reg;
            end
            if (en && v2_reg && last2_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // mac pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            row1_reg   <= i_reg;
            col1_reg   <= j_reg;
            first1_reg <= (k_reg == '0);
            last1_reg  <= k_last;
            fin1_reg   <= i_last && j_last;
            row2_reg   <= row1_reg;
            col2_reg   <= col1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            fin2_reg   <= fin1_reg;
            prod_reg   <= $signed(a_rd_reg) * $signed(b_rd_reg);
            if (v2_reg) begin
                acc_reg <= acc_sum;
            end
            if (v2_reg && last2_reg) begin
                m_product_value <= acc_sum;
                m_out_row       <= OUT_IDX_W'(row2_reg);
                m_out_col       <= OUT_IDX_W'(col2_reg);
                m_last_result   <= fin2_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;

    assign status.resync     = resync_reg;
    assign status.div_done   = (dcnt_reg == '0);
    assign status.complete   = complete;
    assign status.loading_b  = loading_b_reg;
    assign status.issue_last = i_last && j_last && k_last;
    assign status.en         = en;
    assign status.pipe_empty = !v1_reg && !v2_reg;

endmodule
